@@ sv/modular_inverse_top_defines.svh @@
// Assertion macros shared by the modular inverse RTL.
// Needs clk and rst_n in scope at each point of use.
`ifndef MODULAR_INVERSE_TOP_DEFINES_SVH
`define MODULAR_INVERSE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MI_CHECK_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MI_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Plain invariant, checked out of reset.
`define MI_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

@@ sv/mi_pkg.sv @@
// Shared types and constants for the modular inverse block.
// No dependencies; used by mi_ctrl, mi_dp and modular_inverse_top.
package mi_pkg;

    localparam int FIELD_W   = 32;   // width of every payload field
    localparam int DEF_WIDTH = 32;   // default operand width

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture value/modulus, seed coefficients
        logic div_init;   // start a division of a_reg by b_reg
        logic div_step;   // one restoring-division bit
        logic commit;     // shift the remainder sequence by one step
        logic finish;     // normalize and register the result
    } mi_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic b_zero;     // current remainder is zero: Euclid is done
    } mi_sts_t;

endpackage

@@ sv/mi_ctrl.sv @@
// Controller FSM for the modular inverse block: sequencing and handshakes.
// Depends on mi_pkg and modular_inverse_top_defines.svh.
`include "modular_inverse_top_defines.svh"

module mi_ctrl #(
    parameter int WIDTH = mi_pkg::DEF_WIDTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output mi_pkg::mi_cmd_t cmd,
    input  mi_pkg::mi_sts_t sts
);
    import mi_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(WIDTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_COMMIT,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd            = '0;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.b_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_CHECK;
            end
            S_FINISH:
            begin
                // result register free, or being drained this cycle
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.finish     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    `MI_CHECK(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
    `MI_CHECK_NEXT(a_div_len, (state_reg == S_DIV) && (cnt_reg == LAST), cmd.commit, "division did not end after WIDTH steps")
    `MI_CHECK_IMPL(a_rsp_src, $rose(rsp_valid_reg), $past(cmd.finish), "result valid without finish")

endmodule

@@ sv/mi_dp.sv @@
// Datapath for the modular inverse block: remainders, Bezout coefficients,
// shared restoring divider and result registers. Depends on mi_pkg and the defines header.
`include "modular_inverse_top_defines.svh"

module mi_dp #(
    parameter int WIDTH = mi_pkg::DEF_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [mi_pkg::FIELD_W-1:0] value,
    input  logic [mi_pkg::FIELD_W-1:0] modulus,
    output logic [mi_pkg::FIELD_W-1:0] inverse,
    output logic                       exists,
    input  mi_pkg::mi_cmd_t            cmd,
    output mi_pkg::mi_sts_t            sts
);
    import mi_pkg::*;

    // coefficients stay within (-2m, 2m): two guard bits over the operand
    localparam int CW = WIDTH + 2;

    logic [WIDTH-1:0] a_reg;     // previous remainder / dividend
    logic [WIDTH-1:0] b_reg;     // current remainder / divisor
    logic [WIDTH-1:0] m_reg;
    logic [WIDTH-1:0] r_reg;     // partial remainder of the division
    logic [WIDTH-1:0] q_reg;     // dividend bits still to shift in
    logic [CW-1:0]    cp_reg;    // coefficient paired with a_reg
    logic [CW-1:0]    cc_reg;    // coefficient paired with b_reg
    logic [CW-1:0]    acc_reg;   // running quotient * cc_reg
    logic [FIELD_W-1:0] inverse_reg;
    logic               exists_reg;

    logic [FIELD_W+WIDTH-1:0] val_ext, mod_ext;
    logic [WIDTH-1:0]         val_op, mod_op;
    logic [WIDTH:0]           r_sh;
    logic [WIDTH+1:0]         diff;
    logic                     ge;
    logic [WIDTH-1:0]         r_next;
    logic [CW-1:0]            acc_next;
    logic [CW-1:0]            co_norm;
    logic                     ok;
    logic [FIELD_W+CW-1:0]    co_ext;

    // operands are the low WIDTH bits of the ports
    assign val_ext = {{WIDTH{1'b0}}, value};
    assign mod_ext = {{WIDTH{1'b0}}, modulus};
    assign val_op  = val_ext[WIDTH-1:0];
    assign mod_op  = mod_ext[WIDTH-1:0];

    // one restoring-division bit; quotient bit folded into acc
    assign r_sh     = {r_reg, q_reg[WIDTH-1]};
    assign diff     = {1'b0, r_sh} - {2'b00, b_reg};
    assign ge       = !diff[WIDTH+1];
    assign r_next   = ge ? diff[WIDTH-1:0] : r_sh[WIDTH-1:0];
    assign acc_next = {acc_reg[CW-2:0], 1'b0} + (ge ? cc_reg : '0);

    // gcd is a_reg once b_reg hits zero; negative coefficient wraps by m
    assign ok      = (a_reg == WIDTH'(1)) && (m_reg != '0);
    assign co_norm = cp_reg[CW-1] ? (cp_reg + {2'b00, m_reg}) : cp_reg;
    assign co_ext  = {{FIELD_W{1'b0}}, co_norm};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            // seeded so the first step yields rem_prev=m, rem_cur=v%m, co 0/1
            a_reg  <= val_op;
            b_reg  <= mod_op;
            m_reg  <= mod_op;
            cp_reg <= CW'(1);
            cc_reg <= '0;
        end
        if (cmd.div_init)
        begin
            r_reg   <= '0;
            q_reg   <= a_reg;
            acc_reg <= '0;
        end
        if (cmd.div_step)
        begin
            r_reg   <= r_next;
            q_reg   <= {q_reg[WIDTH-2:0], 1'b0};
            acc_reg <= acc_next;
        end
        if (cmd.commit)
        begin
            a_reg  <= b_reg;
            b_reg  <= r_reg;
            cp_reg <= cc_reg;
            cc_reg <= cp_reg - acc_reg;
        end
        if (cmd.finish)
        begin
            exists_reg  <= ok;
            inverse_reg <= ok ? co_ext[FIELD_W-1:0] : '0;
        end
    end

    assign sts.b_zero = (b_reg == '0);
    assign inverse    = inverse_reg;
    assign exists     = exists_reg;

    `MI_CHECK_IMPL(a_rem_below_div, cmd.div_step, r_reg < b_reg, "remainder not below divisor")
    `MI_CHECK_IMPL(a_commit_nonzero, cmd.commit, b_reg != '0, "step with zero divisor")
    `MI_CHECK_IMPL(a_finish_done, cmd.finish, b_reg == '0, "finish before Euclid is done")

endmodule

@@ sv/modular_inverse_top.sv @@
// Top level of the modular inverse block (extended Euclid, iterative).
// Depends on mi_pkg, mi_ctrl, mi_dp and modular_inverse_top_defines.svh.
//
//  channel | fields              | handshake             | transfer when
//  --------+---------------------+-----------------------+-----------------------
//  req     | value, modulus      | req_valid / req_stall | req_valid && !req_stall
//  rsp     | inverse, exists     | rsp_valid / rsp_stall | rsp_valid && !rsp_stall
//
// Sequencing: one item at a time. A request runs n Euclid steps (the first one
//   reduces the value by the modulus); each step is one pass of the shared
//   bit-serial divider over WIDTH bits, plus commit and check.
//   n is at most about 1.44*WIDTH + 2.
// Reset: rst_n clears the controller; the block is idle and ready out of reset.
// Stalls: a result waits in its register while rsp_stall is high; a new request
//   is taken meanwhile and only the final write waits for the register to free.

module modular_inverse_top #(
    parameter int WIDTH = mi_pkg::DEF_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic [mi_pkg::FIELD_W-1:0] value,
    input  logic [mi_pkg::FIELD_W-1:0] modulus,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic [mi_pkg::FIELD_W-1:0] inverse,
    output logic                       exists
);
    import mi_pkg::*;

    mi_cmd_t cmd;   // sequencing from the FSM
    mi_sts_t sts;   // loop-exit status back to the FSM

    mi_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // value/modulus are sampled only on the load command, i.e. on the
    // request transfer, so they need not be held afterwards
    mi_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .value   (value),
        .modulus (modulus),
        .inverse (inverse),
        .exists  (exists),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
